@@ rtl/sws_pkg.sv @@
`default_nettype none
package sws_pkg;

  localparam int POS_W     = 24;
  localparam int MAX_CELLS = 64;
  localparam int CELL_W    = $clog2(MAX_CELLS);
  localparam int CNT_W     = 7;
  localparam int CFG_W     = 16;
  localparam int SQ_W      = 50;
  localparam int NUM_W     = 42;
  localparam int DEN_W     = 26;
  localparam int RES_W     = 25;
  localparam int SQRT_STEPS = 25;
  localparam int DIV_STEPS  = 17;

  typedef struct packed {
    logic                    action;
    logic                    position_valid;
    logic signed [POS_W-1:0] position_x;
    logic signed [POS_W-1:0] position_y;
    logic signed [POS_W-1:0] position_z;
    logic [15:0]             elapsed_ms;
  } in_t;

  typedef struct packed {
    logic [1:0]              task_status;
    logic signed [POS_W-1:0] setpoint_x;
    logic signed [POS_W-1:0] setpoint_y;
    logic signed [POS_W-1:0] setpoint_z;
    logic [5:0]              grid_column;
    logic [5:0]              grid_row;
    logic                    is_hovering;
  } out_t;

  typedef enum logic [1:0] {
    PH_MOVING, PH_HOVERING, PH_FINISHED, PH_FAILED
  } phase_t;

  typedef enum logic [1:0] {
    TS_RUNNING, TS_FINISHED, TS_FAILED
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_EVAL, S_WPT, S_ERR, S_HOVER, S_DIST, S_SQRT, S_SCALE, S_DIV, S_DONE
  } seq_t;

  typedef enum logic [2:0] {
    REG_PITCH, REG_CELLS_X, REG_CELLS_Y, REG_HOVER_TIME,
    REG_RADIUS_XY, REG_TOL_Z, REG_MAX_STEP, REG_MODE
  } reg_idx_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } iter_ctl_t;

endpackage
`default_nettype wire

@@ rtl/sws_mul.sv @@
`default_nettype none
module sws_mul (
  input  wire logic        clk,
  input  wire logic [23:0] a,
  input  wire logic [23:0] b,
  output logic      [47:0] p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule
`default_nettype wire

@@ rtl/sws_iter.sv @@
`default_nettype none
module sws_iter (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire sws_pkg::iter_ctl_t         ctl,
  input  wire logic [sws_pkg::SQ_W-1:0]   rad,
  input  wire logic [sws_pkg::NUM_W-1:0]  num,
  input  wire logic [sws_pkg::DEN_W-1:0]  den,
  output logic                            done,
  output logic [sws_pkg::RES_W-1:0]       res
);

  logic        busy_r, busy_nxt;
  logic        div_r, div_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        done_r, done_nxt;
  logic [28:0] rem_r, rem_nxt;
  logic [24:0] acc_r, acc_nxt;
  logic [49:0] src_r, src_nxt;
  logic [25:0] den_r, den_nxt;
  logic [28:0] cur;
  logic [28:0] trial;
  logic [29:0] diff;
  logic        geq;

  // one shared subtractor: sqrt takes two radicand bits a step, divide one numerator bit
  assign cur   = div_r ? {rem_r[27:0], src_r[49]} : {rem_r[26:0], src_r[49:48]};
  assign trial = div_r ? {3'b0, den_r} : {2'b0, acc_r, 2'b01};
  assign diff  = {1'b0, cur} - {1'b0, trial};
  assign geq   = !diff[29];

  always_comb begin
    busy_nxt = busy_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    acc_nxt  = acc_r;
    src_nxt  = src_r;
    den_nxt  = den_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      div_nxt  = ctl.is_div;
      acc_nxt  = '0;
      den_nxt  = den;
      if (ctl.is_div) begin
        // quotient fits in DIV_STEPS bits, so the top part is already below the divisor
        rem_nxt = {4'b0, num[41:17]};
        src_nxt = {num[16:0], 33'b0};
        cnt_nxt = 5'(sws_pkg::DIV_STEPS);
      end else begin
        rem_nxt = '0;
        src_nxt = rad;
        cnt_nxt = 5'(sws_pkg::SQRT_STEPS);
      end
    end else if (busy_r) begin
      rem_nxt = geq ? diff[28:0] : cur;
      acc_nxt = {acc_r[23:0], geq};
      src_nxt = div_r ? {src_r[48:0], 1'b0} : {src_r[47:0], 2'b00};
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      div_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      div_r  <= div_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    acc_r <= acc_nxt;
    src_r <= src_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign res  = acc_r;

endmodule
`default_nettype wire

@@ rtl/serpentine_waypoint_sequencer.sv @@
// channel | direction | handshake             | payload
// in_     | input     | in_valid / in_stall   | sws_pkg::in_t
// out_    | output    | out_valid / out_stall | sws_pkg::out_t
// cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one request at a time; a start or a tick that moves nothing, hovering, arriving,
// snapping and slewing each take their own path to the output register; slewing uses
// squares, a 25-step square root and three 17-step divides through one multiplier
// and one iterative sqrt/divide unit.
// in_stall is high from acceptance until the result is loaded in the output register.
// synchronous active-low reset loads the register defaults and clears the task state.
// a stalled result holds; the next request is taken while it waits.
`default_nettype none
module serpentine_waypoint_sequencer (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire sws_pkg::in_t   in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output sws_pkg::out_t       out_data,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [2:0]     cfg_index,
  input  wire logic [15:0]    cfg_data
);

  function automatic logic [23:0] sat_way(input logic [23:0] o, input logic [21:0] off,
                                          input logic neg);
    logic [25:0] s;
    logic [23:0] r;
    s = neg ? ({{2{o[23]}}, o} - {4'b0, off}) : ({{2{o[23]}}, o} + {4'b0, off});
    if (!s[25] && s[24:23] != 2'b00) r = 24'h7FFFFF;
    else if (s[25] && s[24:23] != 2'b11) r = 24'h800000;
    else r = s[23:0];
    return r;
  endfunction

  function automatic logic [24:0] sdiff(input logic [23:0] a, input logic [23:0] b);
    return {a[23], a} - {b[23], b};
  endfunction

  function automatic logic [23:0] mag(input logic [24:0] d);
    logic [24:0] n;
    n = d[24] ? (25'd0 - d) : d;
    return n[23:0];
  endfunction

  // configuration
  logic [15:0] pitch_r, hov_time_r, rad_r, tol_r, mstep_r;
  logic [6:0]  cx_r, cy_r;
  logic [4:0]  mode_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_r    <= 16'd800;
      cx_r       <= 7'd5;
      cy_r       <= 7'd5;
      hov_time_r <= 16'd800;
      rad_r      <= 16'd120;
      tol_r      <= 16'd150;
      mstep_r    <= 16'd30;
      mode_r     <= 5'd4;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sws_pkg::REG_PITCH:      pitch_r    <= cfg_data;
        sws_pkg::REG_CELLS_X:    cx_r       <= cfg_data[6:0];
        sws_pkg::REG_CELLS_Y:    cy_r       <= cfg_data[6:0];
        sws_pkg::REG_HOVER_TIME: hov_time_r <= cfg_data;
        sws_pkg::REG_RADIUS_XY:  rad_r      <= cfg_data;
        sws_pkg::REG_TOL_Z:      tol_r      <= cfg_data;
        sws_pkg::REG_MAX_STEP:   mstep_r    <= cfg_data;
        sws_pkg::REG_MODE:       mode_r     <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // sequencer and task state
  sws_pkg::seq_t    st_r, st_nxt;
  sws_pkg::phase_t  phase_r, phase_nxt;
  sws_pkg::status_t status_r, status_nxt;
  logic [2:0]  k_r, k_nxt;
  logic [1:0]  ax_r, ax_nxt;
  logic [5:0]  line_r, line_nxt, step_r, step_nxt;
  logic [23:0] org_x_r, org_x_nxt, org_y_r, org_y_nxt, alt_r, alt_nxt;
  logic [23:0] cmd_x_r, cmd_x_nxt, cmd_y_r, cmd_y_nxt, cmd_z_r, cmd_z_nxt;
  logic [16:0] hov_r, hov_nxt;
  logic        out_valid_r, out_valid_nxt;
  sws_pkg::out_t out_r, out_nxt;
  sws_pkg::in_t  item_r, item_nxt;
  logic [23:0] wx_r, wx_nxt, wy_r, wy_nxt;
  logic [49:0] acc_r, acc_nxt;
  logic [24:0] dist_r, dist_nxt;

  // shared units
  logic [23:0] mul_a, mul_b;
  logic [47:0] prod;
  sws_pkg::iter_ctl_t it_ctl;
  logic [41:0] it_num;
  logic        it_done;
  logic [24:0] it_res;

  sws_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(prod));

  sws_iter u_iter (
    .clk(clk), .rst_n(rst_n), .ctl(it_ctl), .rad(acc_r), .num(it_num),
    .den({dist_r, 1'b0}), .done(it_done), .res(it_res)
  );

  // grid geometry from the counters
  logic [6:0]  effx, effy, len, cnt, along7;
  logic [5:0]  col, row;
  logic        ok, last_in_line, adv_step_more, adv_line_more;
  logic [24:0] ex, ey, ez, dx, dy, dz, dsel;

  always_comb begin
    effx = (cx_r > 7'(sws_pkg::MAX_CELLS)) ? 7'(sws_pkg::MAX_CELLS) : cx_r;
    effy = (cy_r > 7'(sws_pkg::MAX_CELLS)) ? 7'(sws_pkg::MAX_CELLS) : cy_r;
    len  = mode_r[0] ? effy : effx;
    cnt  = mode_r[0] ? effx : effy;
    ok   = ({1'b0, line_r} < cnt) && ({1'b0, step_r} < len);
    // odd lines run backward
    along7 = line_r[0] ? (len - 7'd1 - {1'b0, step_r}) : {1'b0, step_r};
    col  = mode_r[0] ? line_r : along7[5:0];
    row  = mode_r[0] ? along7[5:0] : line_r;
    last_in_line  = ({1'b0, step_r} + 7'd1) == len;
    adv_step_more = ({1'b0, step_r} + 7'd1) < len;
    adv_line_more = ({1'b0, line_r} + 7'd1) < cnt;
    ex = sdiff(item_r.position_x, wx_r);
    ey = sdiff(item_r.position_y, wy_r);
    ez = sdiff(item_r.position_z, alt_r);
    dx = sdiff(wx_r, cmd_x_r);
    dy = sdiff(wy_r, cmd_y_r);
    dz = sdiff(alt_r, cmd_z_r);
    case (ax_r)
      2'd0:    dsel = dx;
      2'd1:    dsel = dy;
      default: dsel = dz;
    endcase
  end

  assign it_num = {1'b0, prod[39:0], 1'b0} + {17'b0, dist_r};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st_r)
      sws_pkg::S_WPT: begin
        mul_a = {18'b0, (k_r == 3'd0) ? col : row};
        mul_b = {8'b0, pitch_r};
      end
      sws_pkg::S_ERR: begin
        case (k_r)
          3'd0:    begin mul_a = mag(ex); mul_b = mag(ex); end
          3'd1:    begin mul_a = mag(ey); mul_b = mag(ey); end
          default: begin mul_a = {8'b0, rad_r}; mul_b = {8'b0, rad_r}; end
        endcase
      end
      sws_pkg::S_DIST: begin
        case (k_r)
          3'd0:    begin mul_a = mag(dx); mul_b = mag(dx); end
          3'd1:    begin mul_a = mag(dy); mul_b = mag(dy); end
          3'd2:    begin mul_a = mag(dz); mul_b = mag(dz); end
          default: begin mul_a = {8'b0, mstep_r}; mul_b = {8'b0, mstep_r}; end
        endcase
      end
      sws_pkg::S_SCALE: begin
        mul_a = mag(dsel);
        mul_b = {8'b0, mstep_r};
      end
      default: ;
    endcase
  end

  always_comb begin
    logic        stop;
    logic [17:0] hsum;
    logic [16:0] hsat;
    logic [24:0] qs;
    logic [24:0] nc;
    logic [23:0] csel;

    st_nxt = st_r;  phase_nxt = phase_r;  status_nxt = status_r;
    k_nxt = k_r;  ax_nxt = ax_r;  line_nxt = line_r;  step_nxt = step_r;
    org_x_nxt = org_x_r;  org_y_nxt = org_y_r;  alt_nxt = alt_r;
    cmd_x_nxt = cmd_x_r;  cmd_y_nxt = cmd_y_r;  cmd_z_nxt = cmd_z_r;
    hov_nxt = hov_r;  item_nxt = item_r;  wx_nxt = wx_r;  wy_nxt = wy_r;
    acc_nxt = acc_r;  dist_nxt = dist_r;
    out_nxt = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    it_ctl = '0;
    stop = !mode_r[1] || last_in_line;
    hsum = {1'b0, hov_r} + {2'b0, item_r.elapsed_ms};
    hsat = hsum[17] ? 17'h1FFFF : hsum[16:0];
    qs   = dsel[24] ? (25'd0 - {8'b0, it_res[16:0]}) : {8'b0, it_res[16:0]};
    case (ax_r)
      2'd0:    csel = cmd_x_r;
      2'd1:    csel = cmd_y_r;
      default: csel = cmd_z_r;
    endcase
    nc = {csel[23], csel} + qs;

    case (st_r)
      sws_pkg::S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          st_nxt   = sws_pkg::S_EVAL;
        end
      end
      sws_pkg::S_EVAL: begin
        st_nxt = sws_pkg::S_DONE;
        status_nxt = sws_pkg::TS_RUNNING;
        if (!item_r.action) begin
          line_nxt = '0;  step_nxt = '0;  hov_nxt = '0;
          phase_nxt = sws_pkg::PH_MOVING;
          if (!item_r.position_valid || cx_r == 7'd0 || cy_r == 7'd0 || pitch_r == 16'd0)
          begin
            phase_nxt  = sws_pkg::PH_FAILED;
            status_nxt = sws_pkg::TS_FAILED;
          end else begin
            org_x_nxt = item_r.position_x;  cmd_x_nxt = item_r.position_x;
            org_y_nxt = item_r.position_y;  cmd_y_nxt = item_r.position_y;
            alt_nxt   = item_r.position_z;  cmd_z_nxt = item_r.position_z;
            // unless mode bit 2 is set, the start cell is skipped: step once from the origin cell
            if (!mode_r[2]) begin
              if (len > 7'd1) step_nxt = 6'd1;
              else if (cnt > 7'd1) line_nxt = 6'd1;
              else begin
                phase_nxt  = sws_pkg::PH_FINISHED;
                status_nxt = sws_pkg::TS_FINISHED;
              end
            end
          end
        end else if (phase_r == sws_pkg::PH_FAILED) begin
          status_nxt = sws_pkg::TS_FAILED;
        end else if (phase_r == sws_pkg::PH_FINISHED) begin
          status_nxt = sws_pkg::TS_FINISHED;
        end else if (!ok) begin
          phase_nxt  = sws_pkg::PH_FINISHED;
          status_nxt = sws_pkg::TS_FINISHED;
        end else if (item_r.position_valid) begin
          st_nxt = sws_pkg::S_WPT;
          k_nxt  = '0;
        end
      end
      sws_pkg::S_WPT: begin
        k_nxt = k_r + 3'd1;
        if (k_r == 3'd1) wx_nxt = sat_way(org_x_r, prod[21:0], mode_r[3]);
        if (k_r == 3'd2) begin
          wy_nxt = sat_way(org_y_r, prod[21:0], mode_r[4]);
          k_nxt  = '0;
          st_nxt = (phase_r == sws_pkg::PH_HOVERING) ? sws_pkg::S_HOVER : sws_pkg::S_ERR;
        end
      end
      sws_pkg::S_ERR: begin
        k_nxt = k_r + 3'd1;
        if (k_r == 3'd1) acc_nxt = {2'b0, prod};
        if (k_r == 3'd2) acc_nxt = acc_r + {2'b0, prod};
        if (k_r == 3'd3) begin
          k_nxt = '0;
          if (acc_r < {2'b0, prod} && mag(ez) < {8'b0, tol_r}) begin
            // arrived: the command jumps to the waypoint and no slew is computed
            cmd_x_nxt = wx_r;  cmd_y_nxt = wy_r;  cmd_z_nxt = alt_r;
            st_nxt = sws_pkg::S_DONE;
            if (stop && hov_time_r > 16'd1) begin
              hov_nxt   = '0;
              phase_nxt = sws_pkg::PH_HOVERING;
            end else begin
              hov_nxt = '0;
              if (adv_step_more) step_nxt = step_r + 6'd1;
              else if (adv_line_more) begin
                line_nxt = line_r + 6'd1;
                step_nxt = '0;
              end else phase_nxt = sws_pkg::PH_FINISHED;
            end
          end else begin
            st_nxt = sws_pkg::S_DIST;
          end
        end
      end
      sws_pkg::S_HOVER: begin
        cmd_x_nxt = wx_r;  cmd_y_nxt = wy_r;  cmd_z_nxt = alt_r;
        st_nxt = sws_pkg::S_DONE;
        if (hsat >= {1'b0, hov_time_r}) begin
          hov_nxt   = '0;
          phase_nxt = sws_pkg::PH_MOVING;
          if (adv_step_more) step_nxt = step_r + 6'd1;
          else if (adv_line_more) begin
            line_nxt = line_r + 6'd1;
            step_nxt = '0;
          end else phase_nxt = sws_pkg::PH_FINISHED;
        end else begin
          hov_nxt = hsat;
        end
      end
      sws_pkg::S_DIST: begin
        k_nxt = k_r + 3'd1;
        if (k_r == 3'd1) acc_nxt = {2'b0, prod};
        if (k_r == 3'd2 || k_r == 3'd3) acc_nxt = acc_r + {2'b0, prod};
        if (k_r == 3'd4) begin
          k_nxt = '0;
          if (acc_r == '0 || mstep_r == 16'd0 || acc_r <= {2'b0, prod}) begin
            cmd_x_nxt = wx_r;  cmd_y_nxt = wy_r;  cmd_z_nxt = alt_r;
            st_nxt = sws_pkg::S_DONE;
          end else begin
            it_ctl.start = 1'b1;
            st_nxt = sws_pkg::S_SQRT;
          end
        end
      end
      sws_pkg::S_SQRT: begin
        if (it_done) begin
          dist_nxt = it_res;
          ax_nxt   = '0;
          k_nxt    = '0;
          st_nxt   = sws_pkg::S_SCALE;
        end
      end
      sws_pkg::S_SCALE: begin
        k_nxt = k_r + 3'd1;
        if (k_r == 3'd1) begin
          // round to nearest: (2*|d|*step + dist) / (2*dist)
          it_ctl.start  = 1'b1;
          it_ctl.is_div = 1'b1;
          k_nxt  = '0;
          st_nxt = sws_pkg::S_DIV;
        end
      end
      sws_pkg::S_DIV: begin
        if (it_done) begin
          case (ax_r)
            2'd0:    cmd_x_nxt = nc[23:0];
            2'd1:    cmd_y_nxt = nc[23:0];
            default: cmd_z_nxt = nc[23:0];
          endcase
          if (ax_r == 2'd2) st_nxt = sws_pkg::S_DONE;
          else begin
            ax_nxt = ax_r + 2'd1;
            st_nxt = sws_pkg::S_SCALE;
          end
        end
      end
      sws_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt        = 1'b1;
          out_nxt.task_status  = status_r;
          out_nxt.setpoint_x   = cmd_x_r;
          out_nxt.setpoint_y   = cmd_y_r;
          out_nxt.setpoint_z   = cmd_z_r;
          out_nxt.is_hovering  = phase_r == sws_pkg::PH_HOVERING;
          if ((phase_r == sws_pkg::PH_MOVING || phase_r == sws_pkg::PH_HOVERING) && ok) begin
            out_nxt.grid_column = col;
            out_nxt.grid_row    = row;
          end else begin
            out_nxt.grid_column = '0;
            out_nxt.grid_row    = '0;
          end
          st_nxt = sws_pkg::S_IDLE;
        end
      end
      default: st_nxt = sws_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= sws_pkg::S_IDLE;
      phase_r     <= sws_pkg::PH_MOVING;
      status_r    <= sws_pkg::TS_RUNNING;
      k_r         <= '0;
      ax_r        <= '0;
      line_r      <= '0;
      step_r      <= '0;
      org_x_r     <= '0;
      org_y_r     <= '0;
      alt_r       <= '0;
      cmd_x_r     <= '0;
      cmd_y_r     <= '0;
      cmd_z_r     <= '0;
      hov_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      phase_r     <= phase_nxt;
      status_r    <= status_nxt;
      k_r         <= k_nxt;
      ax_r        <= ax_nxt;
      line_r      <= line_nxt;
      step_r      <= step_nxt;
      org_x_r     <= org_x_nxt;
      org_y_r     <= org_y_nxt;
      alt_r       <= alt_nxt;
      cmd_x_r     <= cmd_x_nxt;
      cmd_y_r     <= cmd_y_nxt;
      cmd_z_r     <= cmd_z_nxt;
      hov_r       <= hov_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    wx_r   <= wx_nxt;
    wy_r   <= wy_nxt;
    acc_r  <= acc_nxt;
    dist_r <= dist_nxt;
    out_r  <= out_nxt;
  end

  assign in_stall  = st_r != sws_pkg::S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> st_r == sws_pkg::S_EVAL)
    else $error("accepted request did not start evaluation");

  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(st_r) == sws_pkg::S_DONE)
    else $error("result loaded outside the done step");

  a_iter_owner: assert property (@(posedge clk) disable iff (!rst_n)
    it_done |-> st_r == sws_pkg::S_SQRT || st_r == sws_pkg::S_DIV)
    else $error("iterative unit finished with no step waiting on it");

  a_counters_on_grid: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == sws_pkg::S_WPT |-> ok)
    else $error("waypoint computed for counters outside the grid");
`endif

endmodule
`default_nettype wire
